### sv/lcdns_pkg.sv
// Package for the character-LCD nibble sequencer.
// Holds field widths, command and micro-op codes, the control word and the microcode ROM.
// No dependencies.
package lcdns_pkg;

	localparam int FUNC_W     = 3;
	localparam int BYTE_W     = 8;
	localparam int COL_W      = 7;
	localparam int ROW_POS_W  = 2;
	localparam int ROW_W      = 3;
	localparam int NCOL_W     = 6;
	localparam int NROW_W     = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam int PC_W       = 7;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS    = 1'd1;

	localparam logic [NCOL_W-1:0] NUM_COLUMNS_RST = 6'd16;
	localparam logic [NROW_W-1:0] NUM_ROWS_RST    = 3'd2;

	// Command codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_PRINT    = 3'd0,
		FUNC_RAW_DATA = 3'd1,
		FUNC_RAW_INST = 3'd2,
		FUNC_CLEAR    = 3'd3,
		FUNC_HOME     = 3'd4,
		FUNC_GOTO     = 3'd5,
		FUNC_LIGHT    = 3'd6,
		FUNC_INIT     = 3'd7
	} func_t;

	// Micro-op field codes
	typedef enum logic [1:0] {RS_KEEP, RS_SET, RS_CLR} rs_op_t;
	typedef enum logic [1:0] {NIB_KEEP, NIB_HI, NIB_LO} nib_sel_t;
	typedef enum logic [1:0] {BS_VALUE, BS_CONST, BS_ADDR} byte_sel_t;
	typedef enum logic [1:0] {CUR_NONE, CUR_ADV, CUR_LOAD, CUR_CLR} cur_op_t;
	typedef enum logic [1:0] {SEQ_NEXT, SEQ_END, SEQ_JPRINT} seq_op_t;

	// One microcode word
	typedef struct packed {
		logic              emit;
		rs_op_t            rs_op;
		logic              bl_load;
		logic              e_val;
		nib_sel_t          nib_sel;
		byte_sel_t         byte_sel;
		logic [BYTE_W-1:0] const_byte;
		cur_op_t           cur_op;
		seq_op_t           seq;
		logic [PC_W-1:0]   target;
	} ctrl_t;

	// Step issued from the sequencer to the datapath
	typedef struct packed {
		logic              go;
		logic              emit;
		logic              last;
		rs_op_t            rs_op;
		logic              bl_load;
		logic              e_val;
		nib_sel_t          nib_sel;
		byte_sel_t         byte_sel;
		logic [BYTE_W-1:0] const_byte;
		cur_op_t           cur_op;
	} issue_t;

	// Program entry points
	localparam logic [PC_W-1:0] PC_DATA  = 7'd0;
	localparam logic [PC_W-1:0] PC_INST  = 7'd6;
	localparam logic [PC_W-1:0] PC_CLEAR = 7'd12;
	localparam logic [PC_W-1:0] PC_HOME  = 7'd18;
	localparam logic [PC_W-1:0] PC_GOTO  = 7'd24;
	localparam logic [PC_W-1:0] PC_ADDR  = 7'd25;
	localparam logic [PC_W-1:0] PC_LIGHT = 7'd31;
	localparam logic [PC_W-1:0] PC_INIT  = 7'd32;
	localparam logic [PC_W-1:0] PC_NIB   = 7'd33;
	localparam logic [PC_W-1:0] PC_IBYTE = 7'd45;
	localparam logic [PC_W-1:0] PC_END   = 7'd74;

	localparam ctrl_t CTRL_IDLE = '{
		emit: 1'b0, rs_op: RS_KEEP, bl_load: 1'b0, e_val: 1'b0, nib_sel: NIB_KEEP,
		byte_sel: BS_VALUE, const_byte: 8'h00, cur_op: CUR_NONE, seq: SEQ_NEXT,
		target: 7'd0
	};

	// One of the six expander bytes of a display byte: k 0..2 high nibble, 3..5 low
	function automatic ctrl_t send_word(input rs_op_t rs, input byte_sel_t bs,
			input logic [BYTE_W-1:0] cb, input logic [2:0] k);
		ctrl_t w;
		w            = CTRL_IDLE;
		w.emit       = 1'b1;
		w.rs_op      = rs;
		w.byte_sel   = bs;
		w.const_byte = cb;
		w.nib_sel    = (k < 3'd3) ? NIB_HI : NIB_LO;
		w.e_val      = (k == 3'd1) || (k == 3'd4);
		return w;
	endfunction

	function automatic logic [PC_W-1:0] entry_pc(input logic [FUNC_W-1:0] f);
		logic [PC_W-1:0] p;
		case (func_t'(f))
			FUNC_PRINT:    p = PC_DATA;
			FUNC_RAW_DATA: p = PC_DATA;
			FUNC_RAW_INST: p = PC_INST;
			FUNC_CLEAR:    p = PC_CLEAR;
			FUNC_HOME:     p = PC_HOME;
			FUNC_GOTO:     p = PC_GOTO;
			FUNC_LIGHT:    p = PC_LIGHT;
			default:       p = PC_INIT;
		endcase
		return p;
	endfunction

	// Microcode ROM
	function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
		ctrl_t             w;
		logic [PC_W-1:0]   k;
		logic [BYTE_W-1:0] cb;
		w  = CTRL_IDLE;
		k  = '0;
		cb = '0;
		if (pc < PC_INST) begin
			// data byte, RS high; print continues with the address
			w = send_word(RS_SET, BS_VALUE, 8'h00, pc[2:0]);
			if (pc == PC_INST - 7'd1) begin
				w.cur_op = CUR_ADV;
				w.seq    = SEQ_JPRINT;
				w.target = PC_ADDR;
			end
		end else if (pc < PC_CLEAR) begin
			k = pc - PC_INST;
			w = send_word(RS_CLR, BS_VALUE, 8'h00, k[2:0]);
			if (pc == PC_CLEAR - 7'd1) w.seq = SEQ_END;
		end else if (pc < PC_HOME) begin
			k = pc - PC_CLEAR;
			w = send_word(RS_CLR, BS_CONST, 8'h01, k[2:0]);
			if (pc == PC_HOME - 7'd1) w.seq = SEQ_END;
		end else if (pc < PC_GOTO) begin
			k = pc - PC_HOME;
			w = send_word(RS_CLR, BS_CONST, 8'h02, k[2:0]);
			if (pc == PC_GOTO - 7'd1) begin
				w.cur_op = CUR_CLR;
				w.seq    = SEQ_END;
			end
		end else if (pc == PC_GOTO) begin
			w.cur_op = CUR_LOAD;
		end else if (pc < PC_LIGHT) begin
			k = pc - PC_ADDR;
			w = send_word(RS_CLR, BS_ADDR, 8'h00, k[2:0]);
			if (pc == PC_LIGHT - 7'd1) w.seq = SEQ_END;
		end else if (pc == PC_LIGHT) begin
			w.emit    = 1'b1;
			w.bl_load = 1'b1;
			w.seq     = SEQ_END;
		end else if (pc == PC_INIT) begin
			// drop E and RS, keep nibble and backlight
			w.emit  = 1'b1;
			w.rs_op = RS_CLR;
		end else if (pc < PC_IBYTE) begin
			// three strobes of nibble 3, one of nibble 2
			k            = pc - PC_NIB;
			w.emit       = 1'b1;
			w.byte_sel   = BS_CONST;
			w.nib_sel    = NIB_HI;
			w.const_byte = (k < 7'd9) ? 8'h30 : 8'h20;
			w.e_val      = (k == 7'd1) || (k == 7'd4) || (k == 7'd7) || (k == 7'd10);
		end else if (pc <= PC_END) begin
			k = pc - PC_IBYTE;
			if (k < 7'd6) begin
				cb = 8'h06;
			end else if (k < 7'd12) begin
				cb = 8'h0e;
				k  = k - 7'd6;
			end else if (k < 7'd18) begin
				cb = 8'h0c;
				k  = k - 7'd12;
			end else if (k < 7'd24) begin
				cb = 8'h01;
				k  = k - 7'd18;
			end else begin
				cb = 8'h02;
				k  = k - 7'd24;
			end
			w = send_word(RS_CLR, BS_CONST, cb, k[2:0]);
			if (pc == PC_END) begin
				w.cur_op = CUR_CLR;
				w.seq    = SEQ_END;
			end
		end else begin
			w.seq = SEQ_END;
		end
		return w;
	endfunction

endpackage

### sv/lcdns_cmd_if.sv
// Command channel: one LCD command item with valid/ready.
// Depends on lcdns_pkg for field widths.
interface lcdns_cmd_if;
	import lcdns_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [FUNC_W-1:0]    func;
	logic [BYTE_W-1:0]    value;
	logic [COL_W-1:0]     col_pos;
	logic [ROW_POS_W-1:0] row_pos;
	logic                 light_on;
	modport source(output valid, func, value, col_pos, row_pos, light_on, input ready);
	modport sink(input valid, func, value, col_pos, row_pos, light_on, output ready);
endinterface

### sv/lcdns_res_if.sv
// Result channel: one expander byte item with last flag, valid/ready.
// Depends on lcdns_pkg for field widths.
interface lcdns_res_if;
	import lcdns_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] expander_byte;
	logic              last;
	modport source(output valid, expander_byte, last, input ready);
	modport sink(input valid, expander_byte, last, output ready);
endinterface

### sv/lcdns_useq.sv
// Microcode sequencer: step counter, ROM fetch, conditional jump, step issue.
// Depends on lcdns_pkg.
module lcdns_useq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  logic [lcdns_pkg::FUNC_W-1:0]   cmd_func,
	input  logic                           stall,
	output logic                           cmd_ready,
	output lcdns_pkg::issue_t              issue
);
	import lcdns_pkg::*;

	logic              busy_q;
	logic [PC_W-1:0]   pc_q;
	logic [FUNC_W-1:0] func_q;
	ctrl_t             cw;
	logic              step;
	logic              is_print;
	logic              taken;
	logic              seq_end;

	assign cmd_ready = !busy_q;
	assign step      = busy_q && !stall;
	assign is_print  = (func_q == FUNC_PRINT);

	// Fetch and decode
	always_comb begin
		cw      = rom(pc_q);
		taken   = 1'b0;
		seq_end = 1'b0;
		case (cw.seq)
			SEQ_END:    seq_end = 1'b1;
			SEQ_JPRINT: begin
				taken   = is_print;
				seq_end = !is_print;
			end
			default:    seq_end = 1'b0;
		endcase
		issue.go         = step;
		issue.emit       = cw.emit;
		issue.last       = seq_end;
		issue.rs_op      = cw.rs_op;
		issue.bl_load    = cw.bl_load;
		issue.e_val      = cw.e_val;
		issue.nib_sel    = cw.nib_sel;
		issue.byte_sel   = cw.byte_sel;
		issue.const_byte = cw.const_byte;
		// cursor advance only for a printed character
		issue.cur_op     = (cw.cur_op == CUR_ADV && !is_print) ? CUR_NONE : cw.cur_op;
	end

	// Step counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
			func_q <= '0;
		end else if (!busy_q) begin
			if (cmd_valid) begin
				busy_q <= 1'b1;
				pc_q   <= entry_pc(cmd_func);
				func_q <= cmd_func;
			end
		end else if (step) begin
			if (seq_end) busy_q <= 1'b0;
			pc_q <= taken ? cw.target : pc_q + 7'd1;
		end
	end

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		issue.go && issue.last |=> !busy_q) else $error("busy after final step");
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		issue.go && issue.last |-> issue.emit) else $error("final step sends no byte");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && stall |=> $stable(pc_q)) else $error("step counter moved under stall");

endmodule

### sv/lcdns_datapath.sv
// Datapath: config registers, command fields, cursor, port image and output register.
// Depends on lcdns_pkg; driven by lcdns_useq issue words.
module lcdns_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_fire,
	input  logic [lcdns_pkg::BYTE_W-1:0]      cmd_value,
	input  logic [lcdns_pkg::COL_W-1:0]       cmd_col_pos,
	input  logic [lcdns_pkg::ROW_POS_W-1:0]   cmd_row_pos,
	input  logic                              cmd_light_on,
	input  lcdns_pkg::issue_t                 issue,
	input  logic                              cfg_we,
	input  logic [lcdns_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lcdns_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              res_ready,
	output logic                              stall,
	output logic                              res_valid,
	output logic [lcdns_pkg::BYTE_W-1:0]      res_byte,
	output logic                              res_last
);
	import lcdns_pkg::*;

	logic [NCOL_W-1:0]    num_columns_q;
	logic [NROW_W-1:0]    num_rows_q;
	logic [BYTE_W-1:0]    value_q;
	logic [COL_W-1:0]     col_pos_q;
	logic [ROW_POS_W-1:0] row_pos_q;
	logic                 light_q;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [BYTE_W-1:0]    img_q;
	logic                 res_valid_q;
	logic [BYTE_W-1:0]    res_byte_q;
	logic                 res_last_q;

	logic [COL_W-1:0]     addr;
	logic [BYTE_W-1:0]    sel_byte;
	logic [3:0]           nib;
	logic                 rs;
	logic [BYTE_W-1:0]    img_n;
	logic [COL_W-1:0]     col_inc;
	logic [ROW_W-1:0]     row_inc;

	assign stall     = res_valid_q && !res_ready;
	assign res_valid = res_valid_q;
	assign res_byte  = res_byte_q;
	assign res_last  = res_last_q;

	// DDRAM address: rows 2 and 3 alias rows 0 and 1
	assign addr    = {row_q[0], 6'd0} + col_q;
	assign col_inc = col_q + 7'd1;
	assign row_inc = row_q + 3'd1;

	// Next port image
	always_comb begin
		case (issue.byte_sel)
			BS_CONST: sel_byte = issue.const_byte;
			BS_ADDR:  sel_byte = {1'b1, addr};
			default:  sel_byte = value_q;
		endcase
		case (issue.nib_sel)
			NIB_HI:  nib = sel_byte[7:4];
			NIB_LO:  nib = sel_byte[3:0];
			default: nib = img_q[7:4];
		endcase
		case (issue.rs_op)
			RS_SET:  rs = 1'b1;
			RS_CLR:  rs = 1'b0;
			default: rs = img_q[0];
		endcase
		img_n = {nib, (issue.bl_load ? light_q : img_q[3]), issue.e_val, 1'b0, rs};
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_columns_q <= NUM_COLUMNS_RST;
			num_rows_q    <= NUM_ROWS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_COLUMNS: num_columns_q <= cfg_data[NCOL_W-1:0];
				CFG_NUM_ROWS:    num_rows_q    <= cfg_data[NROW_W-1:0];
				default:         ;
			endcase
		end
	end

	// Command fields
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			value_q   <= cmd_value;
			col_pos_q <= cmd_col_pos;
			row_pos_q <= cmd_row_pos;
			light_q   <= cmd_light_on;
		end
	end

	// Cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (issue.go) begin
			case (issue.cur_op)
				CUR_ADV: begin
					if (col_inc == {1'b0, num_columns_q}) begin
						col_q <= '0;
						row_q <= (row_inc == num_rows_q) ? '0 : row_inc;
					end else begin
						col_q <= col_inc;
					end
				end
				CUR_LOAD: begin
					col_q <= col_pos_q;
					row_q <= {1'b0, row_pos_q};
				end
				CUR_CLR: begin
					col_q <= '0;
					row_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Port image and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_q       <= '0;
			res_valid_q <= 1'b0;
		end else if (issue.go && issue.emit) begin
			img_q       <= img_n;
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue.go && issue.emit) begin
			res_byte_q <= img_n;
			res_last_q <= issue.last;
		end
	end

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		issue.go && issue.emit |=> res_valid_q) else $error("sent byte not presented");
	a_end_e_low: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_last_q |-> !res_byte_q[2]) else $error("command ends with E high");
	a_no_step_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> !issue.go) else $error("step issued into a full output register");

endmodule

### sv/char_lcd_nibble_sequencer.sv
// Character-LCD nibble sequencer, top level. An accepted command runs a microcode program
// that sends one expander byte per cycle unless the output stalls, which holds the step
// counter, which is loaded at accept; each byte goes out through the output register.
// Goto first loads the cursor. Bytes: print 12, raw/clear/home 6, goto 6, light 1, init 43.
// Reset clears cursor and port image and sets 16 columns by 2 rows.
// Depends on lcdns_pkg, lcdns_cmd_if, lcdns_res_if, lcdns_useq, lcdns_datapath.
module char_lcd_nibble_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	lcdns_cmd_if.sink                         cmd,
	lcdns_res_if.source                       res,
	input  logic                              cfg_we,
	input  logic [lcdns_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lcdns_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lcdns_pkg::*;

	issue_t issue;
	logic   stall;
	logic   cmd_ready;
	logic   cmd_fire;

	assign cmd.ready = cmd_ready;
	assign cmd_fire  = cmd.valid && cmd_ready;

	lcdns_useq u_useq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_func  (cmd.func),
		.stall     (stall),
		.cmd_ready (cmd_ready),
		.issue     (issue)
	);

	lcdns_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_fire     (cmd_fire),
		.cmd_value    (cmd.value),
		.cmd_col_pos  (cmd.col_pos),
		.cmd_row_pos  (cmd.row_pos),
		.cmd_light_on (cmd.light_on),
		.issue        (issue),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.res_ready    (res.ready),
		.stall        (stall),
		.res_valid    (res.valid),
		.res_byte     (res.expander_byte),
		.res_last     (res.last)
	);

endmodule
